// File: sv/srfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srfc_pkg;

  // Time stamps and windows
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned WinBits    = 16;
  // Field widths
  localparam int unsigned CmdBits    = 3;
  localparam int unsigned PosBits    = 8;
  localparam int unsigned ThrBits    = 7;
  localparam int unsigned SpeedBits  = 10;
  localparam int unsigned MotorBits  = 11;
  // Configuration port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  // Reset values of the configuration registers
  localparam logic [WinBits-1:0]   RstReverseTime  = 16'd200;
  localparam logic [ThrBits-1:0]   RstLostTurnThr  = 7'd70;
  localparam logic [ThrBits-1:0]   RstAimThr       = 7'd60;
  localparam logic [SpeedBits-1:0] RstSearchSpeed  = 10'd200;
  localparam logic [SpeedBits-1:0] RstAttackSpeed  = 10'd500;
  localparam logic [SpeedBits-1:0] RstReverseSpeed = 10'd600;
  localparam logic [SpeedBits-1:0] RstReverseSlow  = 10'd300;

  typedef enum logic [CmdBits-1:0] {
    CMD_NONE  = 3'd0,
    CMD_READY = 3'd1,
    CMD_FIGHT = 3'd2,
    CMD_STOP  = 3'd3
  } cmd_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_REVERSE_TIME  = 3'd0,
    REG_LOST_TURN_THR = 3'd1,
    REG_AIM_THR       = 3'd2,
    REG_SEARCH_SPEED  = 3'd3,
    REG_ATTACK_SPEED  = 3'd4,
    REG_REVERSE_SPEED = 3'd5,
    REG_REVERSE_SLOW  = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    MODE_NONE  = 4'b0001,
    MODE_READY = 4'b0010,
    MODE_FIGHT = 4'b0100,
    MODE_STOP  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [WinBits-1:0]   reverse_time;
    logic [ThrBits-1:0]   lost_turn_thr;
    logic [ThrBits-1:0]   aim_thr;
    logic [SpeedBits-1:0] search_speed;
    logic [SpeedBits-1:0] attack_speed;
    logic [SpeedBits-1:0] reverse_speed;
    logic [SpeedBits-1:0] reverse_slow;
  } cfg_t;

  typedef struct packed {
    logic [CmdBits-1:0]  command;
    logic                border_right;
    logic                border_left;
    logic                target_seen;
    logic [PosBits-1:0]  target_position;
    logic [TimeBits-1:0] time_ms;
  } item_t;

  typedef struct packed {
    mode_e               mode;
    logic [TimeBits-1:0] window_start;
    logic [WinBits-1:0]  window_length;
    logic                reversing;
    logic                line_now;
    logic                line_before;
    logic [PosBits-1:0]  last_position;
  } state_t;

  localparam state_t StateReset = '{
    mode:          MODE_NONE,
    window_start:  '0,
    window_length: '0,
    reversing:     1'b0,
    line_now:      1'b0,
    line_before:   1'b0,
    last_position: '0
  };

endpackage

`default_nettype wire

// File: sv/srfc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module srfc_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wr_en_i,
  input  wire logic [srfc_pkg::CfgIdxBits-1:0]     wr_index_i,
  input  wire logic [srfc_pkg::CfgDataBits-1:0]    wr_data_i,
  output srfc_pkg::cfg_t                           cfg_o
);

  srfc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        srfc_pkg::REG_REVERSE_TIME:  cfg_d.reverse_time  = wr_data_i;
        srfc_pkg::REG_LOST_TURN_THR: cfg_d.lost_turn_thr = wr_data_i[srfc_pkg::ThrBits-1:0];
        srfc_pkg::REG_AIM_THR:       cfg_d.aim_thr       = wr_data_i[srfc_pkg::ThrBits-1:0];
        srfc_pkg::REG_SEARCH_SPEED:  cfg_d.search_speed  = wr_data_i[srfc_pkg::SpeedBits-1:0];
        srfc_pkg::REG_ATTACK_SPEED:  cfg_d.attack_speed  = wr_data_i[srfc_pkg::SpeedBits-1:0];
        srfc_pkg::REG_REVERSE_SPEED: cfg_d.reverse_speed = wr_data_i[srfc_pkg::SpeedBits-1:0];
        srfc_pkg::REG_REVERSE_SLOW:  cfg_d.reverse_slow  = wr_data_i[srfc_pkg::SpeedBits-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse_time  <= srfc_pkg::RstReverseTime;
      cfg_q.lost_turn_thr <= srfc_pkg::RstLostTurnThr;
      cfg_q.aim_thr       <= srfc_pkg::RstAimThr;
      cfg_q.search_speed  <= srfc_pkg::RstSearchSpeed;
      cfg_q.attack_speed  <= srfc_pkg::RstAttackSpeed;
      cfg_q.reverse_speed <= srfc_pkg::RstReverseSpeed;
      cfg_q.reverse_slow  <= srfc_pkg::RstReverseSlow;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/srfc_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One control tick: mode decode, border/reverse window, search and attack.
module srfc_step (
  input  wire srfc_pkg::cfg_t                         cfg_i,
  input  wire srfc_pkg::item_t                        item_i,
  input  wire srfc_pkg::state_t                       state_i,
  output srfc_pkg::state_t                            state_o,
  output logic                                        has_result_o,
  output logic signed [srfc_pkg::MotorBits-1:0]       motor_one_o,
  output logic signed [srfc_pkg::MotorBits-1:0]       motor_two_o
);

  logic [srfc_pkg::CmdBits-1:0]           cmd;
  logic                                   border;
  logic [srfc_pkg::TimeBits-1:0]          ws_eff;
  logic [srfc_pkg::TimeBits-1:0]          elapsed;
  logic [srfc_pkg::WinBits-1:0]           wl_eff;
  logic                                   rev_eff;
  logic                                   in_win;
  logic signed [srfc_pkg::MotorBits-1:0]  ss, as, neg_ss, neg_rs, neg_rl;
  logic signed [srfc_pkg::PosBits:0]      pos_x, last_x, lt_x, at_x, neg_at;

  always_comb begin
    ss     = $signed({1'b0, cfg_i.search_speed});
    as     = $signed({1'b0, cfg_i.attack_speed});
    neg_ss = -ss;
    neg_rs = -$signed({1'b0, cfg_i.reverse_speed});
    neg_rl = -$signed({1'b0, cfg_i.reverse_slow});
    pos_x  = $signed({item_i.target_position[srfc_pkg::PosBits-1], item_i.target_position});
    last_x = $signed({state_i.last_position[srfc_pkg::PosBits-1], state_i.last_position});
    lt_x   = $signed({2'b00, cfg_i.lost_turn_thr});
    at_x   = $signed({2'b00, cfg_i.aim_thr});
    neg_at = -at_x;

    border  = item_i.border_right | item_i.border_left;
    ws_eff  = (state_i.line_now != state_i.line_before) ? item_i.time_ms
                                                        : state_i.window_start;
    wl_eff  = border ? cfg_i.reverse_time : state_i.window_length;
    rev_eff = border | state_i.reversing;
    elapsed = item_i.time_ms - ws_eff;
    in_win  = elapsed < {{(srfc_pkg::TimeBits-srfc_pkg::WinBits){1'b0}}, wl_eff};

    state_o      = state_i;
    has_result_o = 1'b0;
    motor_one_o  = '0;
    motor_two_o  = '0;

    // Fight is latched against none and ready
    cmd = item_i.command;
    if (state_i.mode == srfc_pkg::MODE_FIGHT &&
        (cmd == srfc_pkg::CMD_NONE || cmd == srfc_pkg::CMD_READY)) begin
      cmd = srfc_pkg::CMD_FIGHT;
    end

    unique case (cmd)
      srfc_pkg::CMD_READY: begin
        state_o.window_start = item_i.time_ms;
        state_o.mode         = srfc_pkg::MODE_READY;
      end
      srfc_pkg::CMD_STOP: begin
        state_o.window_length = '0;
        state_o.reversing     = 1'b0;
        state_o.mode          = srfc_pkg::MODE_STOP;
        state_o.window_start  = item_i.time_ms;
        has_result_o          = 1'b1;
      end
      srfc_pkg::CMD_FIGHT: begin
        state_o.window_start = ws_eff;
        state_o.line_before  = state_i.line_now;
        state_o.line_now     = border;
        if (in_win) begin
          state_o.window_length = wl_eff;
          state_o.reversing     = rev_eff;
          motor_one_o = neg_rs;
          motor_two_o = (item_i.border_right != item_i.border_left) ? neg_rl : neg_rs;
        end else begin
          state_o.window_length = '0;
          state_o.reversing     = 1'b0;
        end
        if (!state_o.reversing) begin
          if (!item_i.target_seen) begin
            // spin toward the side the target was last seen on
            if (last_x > lt_x) begin
              motor_one_o = neg_ss;
              motor_two_o = ss;
            end else begin
              motor_one_o = ss;
              motor_two_o = neg_ss;
            end
          end else begin
            if (pos_x < neg_at) begin
              motor_one_o = as;
              motor_two_o = neg_ss;
            end else if (pos_x > at_x) begin
              motor_one_o = neg_ss;
              motor_two_o = as;
            end else begin
              motor_one_o = as;
              motor_two_o = as;
            end
            state_o.last_position = item_i.target_position;
          end
        end
        state_o.mode = srfc_pkg::MODE_FIGHT;
        has_result_o = 1'b1;
      end
      default: begin
        // none outside fight, and the unassigned codes
        state_o.window_start = item_i.time_ms;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/sumo_robot_fight_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sumo robot fight controller.
// Input channel (in_valid_i / in_ready_o): one beat per control tick with the
// remote command, both border flags, target seen flag, bearing and ms time.
// Output channel (out_valid_o / out_ready_i): one beat with both signed motor
// speeds for each fight or stop tick; outside fight mode ready and none, and
// unassigned commands always, update state but produce no beat.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data, always
// accepted; write only while no tick is in flight.
// Path: a result reaches the output register from the input register through
// one compare-and-select pass, and waits in the input register while the
// output register is held.
// Throughput: one tick per cycle while the receiver takes beats, set by the
// combinational state update between the two registers.
// Receiver stall: the output register holds its beat; the input register
// takes one more tick, then in_ready_o drops until the output beat leaves.
// Reset: mode goes to none, window and border history clear, config
// registers return to their defaults, both channels empty.
module sumo_robot_fight_controller_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // tick input
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic [srfc_pkg::CmdBits-1:0]            command_i,
  input  wire logic                                    border_right_i,
  input  wire logic                                    border_left_i,
  input  wire logic                                    target_seen_i,
  input  wire logic signed [srfc_pkg::PosBits-1:0]     target_position_i,
  input  wire logic [srfc_pkg::TimeBits-1:0]           time_ms_i,
  // drive output
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic signed [srfc_pkg::MotorBits-1:0]        motor_one_speed_o,
  output logic signed [srfc_pkg::MotorBits-1:0]        motor_two_speed_o,
  // config writes
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [srfc_pkg::CfgIdxBits-1:0]         cfg_index_i,
  input  wire logic [srfc_pkg::CfgDataBits-1:0]        cfg_data_i
);

  srfc_pkg::cfg_t   cfg;
  srfc_pkg::item_t  item_q;
  srfc_pkg::state_t state_q, state_d;
  logic             item_valid_q;
  logic             out_free, item_fire, in_fire;
  logic             has_result;
  logic signed [srfc_pkg::MotorBits-1:0] m1_d, m2_d, m1_q, m2_q;
  logic             out_valid_q;

  // Config port never stalls
  assign cfg_ready_o = 1'b1;

  srfc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Output register is free when empty or draining this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign item_fire  = item_valid_q && out_free;
  assign in_ready_o = !item_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register: payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.command         <= command_i;
      item_q.border_right    <= border_right_i;
      item_q.border_left     <= border_left_i;
      item_q.target_seen     <= target_seen_i;
      item_q.target_position <= target_position_i;
      item_q.time_ms         <= time_ms_i;
    end
  end

  srfc_step u_step (
    .cfg_i        (cfg),
    .item_i       (item_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .has_result_o (has_result),
    .motor_one_o  (m1_d),
    .motor_two_o  (m2_d)
  );

  // Controller state moves once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srfc_pkg::StateReset;
    end else if (item_fire) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_fire && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire && has_result) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_one_speed_o = m1_q;
  assign motor_two_speed_o = m2_q;

endmodule

`default_nettype wire

// File: sv/srfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module srfc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic [srfc_pkg::MotorBits-1:0]      motor_one_speed_o,
  input wire logic [srfc_pkg::MotorBits-1:0]      motor_two_speed_o,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_o
);

  localparam logic [srfc_pkg::MotorBits-1:0] MotorMin = {1'b1, {(srfc_pkg::MotorBits-1){1'b0}}};

  // With the output side empty, the block always takes a tick
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("input stalled with empty output");

  // A new output beat comes from a tick taken earlier on the input channel
  a_rose_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output beat without a source tick");

  // Drive magnitudes never exceed the 10-bit speed range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_one_speed_o != MotorMin && motor_two_speed_o != MotorMin))
    else $error("motor speed out of range");

  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o) else $error("config write stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motor_one_speed_o)
      && $stable(motor_two_speed_o)) else $error("stalled output beat changed");

endmodule

bind sumo_robot_fight_controller_top srfc_checker u_srfc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .motor_one_speed_o (motor_one_speed_o),
  .motor_two_speed_o (motor_two_speed_o),
  .cfg_valid_i       (cfg_valid_i),
  .cfg_ready_o       (cfg_ready_o)
);

`default_nettype wire

// File: tb/sv/srfc_drive_checker.sv
`timescale 1ns / 1ps

// Watches the tick, drive and config channels, keeps its own copy of the
// controller state, and checks every drive beat against the oldest
// expectation.
module srfc_drive_checker
  import srfc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [CmdBits-1:0]          command_i,
  input  logic                        border_right_i,
  input  logic                        border_left_i,
  input  logic                        target_seen_i,
  input  logic signed [PosBits-1:0]   target_position_i,
  input  logic [TimeBits-1:0]         time_ms_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [MotorBits-1:0] motor_one_speed_i,
  input  logic signed [MotorBits-1:0] motor_two_speed_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CfgIdxBits-1:0]       cfg_index_i,
  input  logic [CfgDataBits-1:0]      cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic signed [MotorBits-1:0] one;
    logic signed [MotorBits-1:0] two;
  } drive_t;

  cfg_t                      regs;
  mode_e                     mode_q;
  logic [TimeBits-1:0]       win_start;
  logic [WinBits-1:0]        win_len;
  logic                      reversing;
  logic                      line_now;
  logic                      line_before;
  logic signed [PosBits-1:0] last_pos;
  drive_t                    drive_q[$];
  int                        mismatches = 0;

  function automatic void load_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] d);
    case (idx)
      REG_REVERSE_TIME:  regs.reverse_time  = d[WinBits-1:0];
      REG_LOST_TURN_THR: regs.lost_turn_thr = d[ThrBits-1:0];
      REG_AIM_THR:       regs.aim_thr       = d[ThrBits-1:0];
      REG_SEARCH_SPEED:  regs.search_speed  = d[SpeedBits-1:0];
      REG_ATTACK_SPEED:  regs.attack_speed  = d[SpeedBits-1:0];
      REG_REVERSE_SPEED: regs.reverse_speed = d[SpeedBits-1:0];
      REG_REVERSE_SLOW:  regs.reverse_slow  = d[SpeedBits-1:0];
      default: ;
    endcase
  endfunction

  function automatic void push_drive(int m1, int m2);
    drive_t d;
    d.one = MotorBits'(m1);
    d.two = MotorBits'(m2);
    drive_q.push_back(d);
  endfunction

  // One control tick through the mode machine and the steering logic.
  function automatic void run_tick(logic [CmdBits-1:0] cmd_in, logic br, logic bl,
                                   logic seen, logic signed [PosBits-1:0] pos,
                                   logic [TimeBits-1:0] now);
    logic [CmdBits-1:0]  cmd;
    logic [TimeBits-1:0] elapsed;
    int ss, atk, rs, rl, lt, aim, m1, m2;
    cmd = cmd_in;
    ss  = int'(regs.search_speed);
    atk = int'(regs.attack_speed);
    rs  = int'(regs.reverse_speed);
    rl  = int'(regs.reverse_slow);
    lt  = int'(regs.lost_turn_thr);
    aim = int'(regs.aim_thr);
    m1  = 0;
    m2  = 0;

    // fight is latched against none and ready
    if (mode_q == MODE_FIGHT && (cmd == CMD_NONE || cmd == CMD_READY)) cmd = CMD_FIGHT;

    if (cmd == CMD_READY) begin
      win_start = now;
      mode_q    = MODE_READY;
      return;
    end
    if (cmd == CMD_STOP) begin
      win_len   = '0;
      reversing = 1'b0;
      mode_q    = MODE_STOP;
      win_start = now;
      push_drive(0, 0);
      return;
    end
    if (cmd != CMD_FIGHT) begin
      win_start = now;
      return;
    end

    // border edge seen on the previous tick restarts the window
    if (line_now != line_before) win_start = now;
    line_before = line_now;
    if (br || bl) begin
      win_len   = regs.reverse_time;
      line_now  = 1'b1;
      reversing = 1'b1;
    end else begin
      line_now = 1'b0;
    end

    elapsed = now - win_start;
    if (elapsed < win_len) begin
      if (br || bl) begin
        win_len   = regs.reverse_time;
        reversing = 1'b1;
      end
      m1 = -rs;
      m2 = (br != bl) ? -rl : -rs;
    end else begin
      win_len   = '0;
      reversing = 1'b0;
    end

    if (!reversing) begin
      if (!seen) begin
        if (int'(last_pos) > lt) begin
          m1 = -ss;
          m2 = ss;
        end else begin
          m1 = ss;
          m2 = -ss;
        end
      end else begin
        if (int'(pos) < -aim) begin
          m1 = atk;
          m2 = -ss;
        end else if (int'(pos) > aim) begin
          m1 = -ss;
          m2 = atk;
        end else begin
          m1 = atk;
          m2 = atk;
        end
        last_pos = pos;
      end
    end

    mode_q = MODE_FIGHT;
    push_drive(m1, m2);
  endfunction

  function automatic void flag_field(string field, logic signed [MotorBits-1:0] want,
                                     logic signed [MotorBits-1:0] got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_t want;
    if (!rst_ni) begin
      regs = '{reverse_time:  RstReverseTime,
               lost_turn_thr: RstLostTurnThr,
               aim_thr:       RstAimThr,
               search_speed:  RstSearchSpeed,
               attack_speed:  RstAttackSpeed,
               reverse_speed: RstReverseSpeed,
               reverse_slow:  RstReverseSlow};
      mode_q      = MODE_NONE;
      win_start   = '0;
      win_len     = '0;
      reversing   = 1'b0;
      line_now    = 1'b0;
      line_before = 1'b0;
      last_pos    = '0;
      drive_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) load_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i)
        run_tick(command_i, border_right_i, border_left_i, target_seen_i,
                 target_position_i, time_ms_i);
      if (out_valid_i && out_ready_i) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: drive beat with nothing expected: %0d %0d", $time,
                     motor_one_speed_i, motor_two_speed_i);
        end else begin
          want = drive_q.pop_front();
          if (motor_one_speed_i !== want.one)
            flag_field("motor_one_speed", want.one, motor_one_speed_i);
          if (motor_two_speed_i !== want.two)
            flag_field("motor_two_speed", want.two, motor_two_speed_i);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= drive_q.size();
  end

endmodule

// File: tb/sv/tb_sumo_robot_fight_controller_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sumo fight controller. The checker beside the
// DUT does all prediction and comparison; this module drives the beats.
module tb_sumo_robot_fight_controller_top;
  import srfc_pkg::*;

  // Cycles with no beat on any channel before the run is declared hung.
  localparam int unsigned StallLimit  = 5000;
  // Long receiver hold-off used once to back the tick pipe up.
  localparam int unsigned HoldCycles  = 300;
  // Counted ticks per config leg; eight legs plus the directed part.
  localparam int unsigned ItemsPerLeg = 100;
  // Pipe is two deep; a ready/none tick may still be inside after the
  // last drive beat has left.
  localparam int unsigned DrainCycles = 6;

  // Command codes with no meaning of their own.
  localparam logic [CmdBits-1:0]    CmdSpareLo = 3'd4;
  localparam logic [CmdBits-1:0]    CmdSpareHi = 3'd7;
  // Config index with no register behind it.
  localparam logic [CfgIdxBits-1:0] RegSpare   = 3'd7;

  // Kinds of register settings.
  localparam int unsigned SetRandom = 0;
  localparam int unsigned SetMax    = 1;
  localparam int unsigned SetZero   = 2;

  logic                        clk_i             = 1'b0;
  logic                        rst_ni            = 1'b0;
  logic                        in_valid_i        = 1'b0;
  logic                        in_ready_o;
  logic [CmdBits-1:0]          command_i         = '0;
  logic                        border_right_i    = 1'b0;
  logic                        border_left_i     = 1'b0;
  logic                        target_seen_i     = 1'b0;
  logic signed [PosBits-1:0]   target_position_i = '0;
  logic [TimeBits-1:0]         time_ms_i         = '0;
  logic                        out_valid_o;
  logic                        out_ready_i       = 1'b0;
  logic signed [MotorBits-1:0] motor_one_speed_o;
  logic signed [MotorBits-1:0] motor_two_speed_o;
  logic                        cfg_valid_i       = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxBits-1:0]       cfg_index_i       = '0;
  logic [CfgDataBits-1:0]      cfg_data_i        = '0;

  int          fail_count;
  int          pending;
  int unsigned send_idle   = 0;   // percent of cycles the sender skips
  int unsigned recv_stall  = 0;   // percent of cycles the receiver stalls
  logic        hold_req    = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned scored;            // ticks that count toward a leg
  cfg_t        cfg_now;           // register values last written

  sumo_robot_fight_controller_top DUT (.*);

  srfc_drive_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .command_i         (command_i),
    .border_right_i    (border_right_i),
    .border_left_i     (border_left_i),
    .target_seen_i     (target_seen_i),
    .target_position_i (target_position_i),
    .time_ms_i         (time_ms_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .motor_one_speed_i (motor_one_speed_o),
    .motor_two_speed_i (motor_two_speed_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Drive-side receiver. A hold request parks ready low for a fixed stretch
  // while the sender keeps offering ticks; otherwise ready is random at the
  // current stall rate.
  initial begin : drive_sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Hang detector: any beat on any channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one tick beat; valid stays up across back-to-back beats and only
  // drops when the sender decides to skip cycles.
  task automatic send_tick(input item_t t);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    command_i         <= t.command;
    border_right_i    <= t.border_right;
    border_left_i     <= t.border_left;
    target_seen_i     <= t.target_seen;
    target_position_i <= t.target_position;
    time_ms_i         <= t.time_ms;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic tick(input logic [CmdBits-1:0] cmd, input logic br, input logic bl,
                      input logic seen, input logic [PosBits-1:0] pos,
                      input logic [TimeBits-1:0] t_ms);
    item_t t;
    t.command         = cmd;
    t.border_right    = br;
    t.border_left     = bl;
    t.target_seen     = seen;
    t.target_position = pos;
    t.time_ms         = t_ms;
    send_tick(t);
  endtask

  // Drop valid, let every expected drive beat drain, then give any
  // result-free tick still in the pipe time to retire.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Config valid is held across a batch and dropped once by the caller.
  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Full register load; bits above each narrow register's width carry junk that
  // must be dropped, and the unused index gets a write that must do nothing.
  task automatic write_all(input cfg_t c);
    cfg_write(RegSpare, CfgDataBits'($urandom));
    cfg_write(REG_REVERSE_TIME, c.reverse_time);
    cfg_write(REG_LOST_TURN_THR, {9'($urandom), c.lost_turn_thr});
    cfg_write(REG_AIM_THR, {9'($urandom), c.aim_thr});
    cfg_write(REG_SEARCH_SPEED, {6'($urandom), c.search_speed});
    cfg_write(REG_ATTACK_SPEED, {6'($urandom), c.attack_speed});
    cfg_write(REG_REVERSE_SPEED, {6'($urandom), c.reverse_speed});
    cfg_write(REG_REVERSE_SLOW, {6'($urandom), c.reverse_slow});
    cfg_valid_i <= 1'b0;
    cfg_now = c;
  endtask

  function automatic cfg_t make_setting(input int unsigned kind);
    cfg_t c;
    case (kind)
      SetMax:  c = '1;
      SetZero: c = '0;
      default: begin
        c.reverse_time  = WinBits'($urandom_range(600));
        c.lost_turn_thr = ThrBits'($urandom);
        c.aim_thr       = ThrBits'($urandom);
        c.search_speed  = SpeedBits'($urandom);
        c.attack_speed  = SpeedBits'($urandom);
        c.reverse_speed = SpeedBits'($urandom);
        c.reverse_slow  = SpeedBits'($urandom);
      end
    endcase
    return c;
  endfunction

  // Bearings cluster on the rails and around both thresholds, where the
  // steering decisions flip.
  function automatic logic [PosBits-1:0] pick_bearing();
    int aim, lost;
    aim  = int'(cfg_now.aim_thr);
    lost = int'(cfg_now.lost_turn_thr);
    case ($urandom_range(6))
      0: return $urandom_range(1) ? 8'h80 : 8'h7F;
      1: return PosBits'(aim + int'($urandom_range(2)) - 1);
      2: return PosBits'(-aim + int'($urandom_range(2)) - 1);
      3: return PosBits'(lost + int'($urandom_range(2)) - 1);
      default: return PosBits'($urandom);
    endcase
  endfunction

  // One match: ready, fight, then a run of mostly latched ticks with time
  // stepping forward so border windows open and close.
  task automatic run_bout();
    logic [TimeBits-1:0] clock_ms;
    logic [CmdBits-1:0]  cmd;
    int unsigned span, step_max, edge_pct, roll, k;
    clock_ms = $urandom;
    if ($urandom_range(3) == 0) clock_ms = '1 - $urandom_range(3000);
    if (cfg_now.reverse_time > 16'd600) begin
      step_max = 4000;
      edge_pct = 3;
    end else begin
      step_max = int'(cfg_now.reverse_time) / 3 + 4;
      edge_pct = 15;
    end
    span = $urandom_range(60, 10);
    tick(CMD_READY, 1'($urandom), 1'($urandom), 1'($urandom), pick_bearing(), clock_ms);
    clock_ms += $urandom_range(step_max);
    tick(CMD_FIGHT, 1'b0, 1'b0, 1'($urandom), pick_bearing(), clock_ms);
    scored++;
    for (k = 0; k < span; k++) begin
      clock_ms += $urandom_range(step_max);
      roll = $urandom_range(99);
      if (roll < 55)      cmd = CMD_NONE;
      else if (roll < 82) cmd = CMD_FIGHT;
      else if (roll < 90) cmd = CMD_READY;
      else if (roll < 96) cmd = CmdBits'($urandom_range(CmdSpareLo, CmdSpareHi));
      else                cmd = CMD_STOP;
      tick(cmd, $urandom_range(99) < edge_pct, $urandom_range(99) < edge_pct,
           $urandom_range(99) < 65, pick_bearing(), clock_ms);
      scored++;
    end
  endtask

  // Fully random ticks, any command, any time.
  task automatic run_noise(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++)
      tick(CmdBits'($urandom_range(7)), 1'($urandom), 1'($urandom), 1'($urandom),
           PosBits'($urandom), $urandom);
  endtask

  initial begin : stimulus
    int unsigned phase, leg, kind;
    cfg_now = make_setting(SetZero);
    cfg_now.reverse_time  = RstReverseTime;
    cfg_now.lost_turn_thr = RstLostTurnThr;
    cfg_now.aim_thr       = RstAimThr;
    cfg_now.search_speed  = RstSearchSpeed;
    cfg_now.attack_speed  = RstAttackSpeed;
    cfg_now.reverse_speed = RstReverseSpeed;
    cfg_now.reverse_slow  = RstReverseSlow;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk on reset register values, no idling.
    tick(CMD_NONE,  0, 0, 0, 8'sd0,   32'd0);         // none before any mode: silent
    tick(CMD_READY, 0, 0, 0, 8'sd0,   32'd10);
    tick(CMD_FIGHT, 0, 0, 0, 8'sd0,   32'd20);        // lost, last bearing low: spin
    tick(CMD_FIGHT, 0, 0, 1, 8'sd127, 32'd30);        // far side: turn
    tick(CMD_NONE,  0, 0, 1, 8'h80,   32'd40);        // latched, bearing -128
    tick(CMD_READY, 0, 0, 1, 8'sd60,  32'd50);        // latched, on threshold: straight
    tick(CMD_FIGHT, 0, 0, 1, 8'sd61,  32'd60);
    tick(CMD_FIGHT, 0, 0, 1, 8'sd71,  32'd70);
    tick(CMD_FIGHT, 0, 0, 0, 8'sd0,   32'd80);        // lost past spin threshold
    tick(CMD_FIGHT, 1, 0, 0, 8'sd0,   32'd100);       // right border: reverse, one slow
    tick(CMD_FIGHT, 0, 0, 0, 8'sd0,   32'd150);       // window restarts on the edge
    tick(CMD_FIGHT, 0, 1, 0, 8'sd0,   32'd200);       // left border alone
    tick(CMD_FIGHT, 1, 1, 0, 8'sd0,   32'd210);       // both borders: full reverse
    tick(CMD_FIGHT, 0, 0, 1, -8'sd61, 32'd500);       // window expired: attack
    tick(CmdSpareLo, 0, 0, 0, 8'sd0,  32'd600);       // spare code: silent
    tick(CMD_NONE,  0, 0, 1, 8'sd5,   32'd610);       // mode still fight
    tick(CMD_STOP,  1, 1, 1, 8'sd5,   32'd620);
    tick(CMD_NONE,  0, 0, 0, 8'sd0,   32'd630);       // after stop: silent
    tick(CmdSpareHi, 1, 1, 1, 8'h7F,  32'd640);
    tick(CMD_READY, 0, 0, 0, 8'sd0,   32'hFFFF_FF00);
    tick(CMD_FIGHT, 1, 0, 0, 8'sd0,   32'hFFFF_FF80);
    tick(CMD_FIGHT, 1, 0, 0, 8'sd0,   32'hFFFF_FFC0); // window restarts near the top
    tick(CMD_FIGHT, 1, 0, 0, 8'sd0,   32'h0000_0050); // still inside across the wrap
    tick(CMD_FIGHT, 0, 0, 1, -8'sd127, 32'h0000_0100);
    tick(CMD_STOP,  1, 1, 1, 8'h55,   32'hFFFF_FFFF);

    // Four idling phases, two register settings each.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      for (leg = 0; leg < 2; leg++) begin
        case (phase * 2 + leg)
          1, 4:    kind = SetMax;
          2, 7:    kind = SetZero;
          default: kind = SetRandom;
        endcase
        settle();
        write_all(make_setting(kind));
        // Back the pipe up once while nothing else stalls the receiver.
        if (phase == 0 && leg == 0) hold_req = 1'b1;
        scored = 0;
        while (scored < ItemsPerLeg) begin
          if ($urandom_range(9) == 0) run_noise($urandom_range(8, 2));
          else run_bout();
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/srfc_pkg.sv
sv/srfc_cfg_regs.sv
sv/srfc_step.sv
sv/sumo_robot_fight_controller_top.sv
sv/srfc_checker.sv
tb/sv/srfc_drive_checker.sv
tb/sv/tb_sumo_robot_fight_controller_top.sv
